// ----- rtl/http_request_byte_parser_macros.svh -----
`ifndef HTTP_REQUEST_BYTE_PARSER_MACROS_SVH
`define HTTP_REQUEST_BYTE_PARSER_MACROS_SVH

// Same-cycle check: when ante holds, cons must hold on the same edge.
`define HRBP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check: when ante holds, cons must hold on the following edge.
`define HRBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/hrbp_pkg.sv -----
`timescale 1ns / 1ps

package hrbp_pkg;

  // default width of the length counters
  localparam int LEN_WIDTH_DEF = 32;

  // field tags
  localparam logic [2:0] FK_NONE    = 3'd0;
  localparam logic [2:0] FK_METHOD  = 3'd1;
  localparam logic [2:0] FK_URI     = 3'd2;
  localparam logic [2:0] FK_VERSION = 3'd3;
  localparam logic [2:0] FK_KEY     = 3'd4;
  localparam logic [2:0] FK_VALUE   = 3'd5;
  localparam logic [2:0] FK_BODY    = 3'd6;

  // committed-field codes
  localparam logic [2:0] FE_NONE    = 3'd0;
  localparam logic [2:0] FE_METHOD  = 3'd1;
  localparam logic [2:0] FE_URI     = 3'd2;
  localparam logic [2:0] FE_VERSION = 3'd3;
  localparam logic [2:0] FE_KEY     = 3'd4;
  localparam logic [2:0] FE_HEADER  = 3'd5;

  // special bytes
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  // "Content-Length" key
  localparam logic [3:0] KEY_LEN     = 4'd14;
  localparam logic [3:0] KEY_POS_MAX = 4'd15;

  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "C";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = "L";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // one result word, packed
  typedef struct packed {
    logic [7:0]  data;
    logic [2:0]  kind;
    logic [2:0]  fend;
    logic        len_hdr;
    logic [31:0] body_len;
    logic [3:0]  state;
    logic        complete;
    logic        error;
  } hrbp_result_t;

endpackage

// ----- rtl/hrbp_fsm.sv -----
`timescale 1ns / 1ps
`include "http_request_byte_parser_macros.svh"

module hrbp_fsm #(
  parameter int LEN_WIDTH = hrbp_pkg::LEN_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,      // byte in stage one moves to the result register
  input  logic [7:0]           byte_in,
  output hrbp_pkg::hrbp_result_t res
);
  import hrbp_pkg::*;

  typedef enum logic [3:0] {
    PH_METHOD   = 4'd0,
    PH_URI      = 4'd1,
    PH_VERSION  = 4'd2,
    PH_KEY      = 4'd3,
    PH_VALUE    = 4'd4,
    PH_VALUE_LF = 4'd5,
    PH_BODY_LF  = 4'd6,
    PH_BODY     = 4'd7,
    PH_COMPLETE = 4'd8,
    PH_ERROR    = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    NUM_BLANK  = 3'd0,
    NUM_SIGN   = 3'd1,
    NUM_DIGITS = 3'd2,
    NUM_DONE   = 3'd3,
    NUM_BAD    = 3'd4
  } num_t;

  localparam int SUM_W = LEN_WIDTH + 4;
  localparam int EXT_W = LEN_WIDTH + 32;

  phase_t               phase_r, phase_nxt;
  logic                 tok_r, tok_nxt;
  logic [3:0]           key_pos_r, key_pos_nxt;
  logic                 key_mis_r, key_mis_nxt;
  logic [LEN_WIDTH-1:0] dsum_r, dsum_nxt;
  num_t                 dflags_r, dflags_nxt;
  logic [LEN_WIDTH-1:0] len_r, len_nxt;
  logic [LEN_WIDTH-1:0] body_cnt_r, body_cnt_nxt;

  logic [2:0]           kind, fend;
  logic                 len_hdr;
  logic                 is_digit, is_blank;
  logic [SUM_W-1:0]     dsum_ext, dsum_x10;
  logic                 dsum_ovf;
  logic [LEN_WIDTH-1:0] body_inc;
  logic [EXT_W-1:0]     len_ext;

  // byte classes
  assign is_digit = (byte_in >= "0") && (byte_in <= "9");
  assign is_blank = (byte_in == CH_SP) || (byte_in inside {[8'h09:8'h0D]});

  // sum*10 + digit; anything above LEN_WIDTH bits is overflow
  assign dsum_ext = {4'd0, dsum_r};
  assign dsum_x10 = (dsum_ext << 3) + (dsum_ext << 1) + {{(SUM_W-4){1'b0}}, byte_in[3:0]};
  assign dsum_ovf = |dsum_x10[SUM_W-1:LEN_WIDTH];

  // saturating body counter
  assign body_inc = (&body_cnt_r) ? body_cnt_r :
                    body_cnt_r + {{(LEN_WIDTH-1){1'b0}}, 1'b1};

  // parser next state
  always_comb begin
    phase_nxt    = phase_r;
    tok_nxt      = tok_r;
    key_pos_nxt  = key_pos_r;
    key_mis_nxt  = key_mis_r;
    dsum_nxt     = dsum_r;
    dflags_nxt   = dflags_r;
    len_nxt      = len_r;
    body_cnt_nxt = body_cnt_r;
    kind         = FK_NONE;
    fend         = FE_NONE;
    len_hdr      = 1'b0;

    case (phase_r)
      PH_METHOD, PH_URI: begin
        if (byte_in == CH_SP) begin
          fend      = (phase_r == PH_METHOD) ? FE_METHOD : FE_URI;
          tok_nxt   = 1'b0;
          phase_nxt = (phase_r == PH_METHOD) ? PH_URI : PH_VERSION;
        end else begin
          kind    = (phase_r == PH_METHOD) ? FK_METHOD : FK_URI;
          tok_nxt = 1'b1;
        end
      end
      PH_VERSION: begin
        if (byte_in == CH_CR) begin
          // dropped, LF commits the version
        end else if (byte_in == CH_LF) begin
          fend        = FE_VERSION;
          tok_nxt     = 1'b0;
          key_pos_nxt = '0;
          key_mis_nxt = 1'b0;
          dsum_nxt    = '0;
          dflags_nxt  = NUM_BLANK;
          phase_nxt   = PH_KEY;
        end else begin
          kind    = FK_VERSION;
          tok_nxt = 1'b1;
        end
      end
      PH_KEY: begin
        if (byte_in == CH_CR) begin
          tok_nxt   = 1'b0;
          phase_nxt = PH_BODY_LF;
        end else if (byte_in == CH_COLON) begin
          fend       = FE_KEY;
          tok_nxt    = 1'b0;
          dsum_nxt   = '0;
          dflags_nxt = NUM_BLANK;
          phase_nxt  = PH_VALUE;
        end else begin
          kind    = FK_KEY;
          tok_nxt = 1'b1;
          // match against the length key as it arrives
          if (key_pos_r >= KEY_LEN || key_char(key_pos_r) != byte_in) key_mis_nxt = 1'b1;
          if (key_pos_r < KEY_POS_MAX) key_pos_nxt = key_pos_r + 4'd1;
        end
      end
      PH_VALUE: begin
        if (byte_in == CH_SP && !tok_r) begin
          // leading space dropped
        end else if (byte_in == CH_CR) begin
          phase_nxt = PH_VALUE_LF;
        end else begin
          kind    = FK_VALUE;
          tok_nxt = 1'b1;
          // leading decimal number scan
          if (dflags_r == NUM_BLANK && is_blank) begin
            // still in leading blanks
          end else if (dflags_r == NUM_BLANK && byte_in == CH_PLUS) begin
            dflags_nxt = NUM_SIGN;
          end else if (dflags_r == NUM_BLANK || dflags_r == NUM_SIGN ||
                       dflags_r == NUM_DIGITS) begin
            if (is_digit) begin
              if (dsum_ovf) begin
                dflags_nxt = NUM_BAD;
              end else begin
                dsum_nxt   = dsum_x10[LEN_WIDTH-1:0];
                dflags_nxt = NUM_DIGITS;
              end
            end else begin
              dflags_nxt = (dflags_r == NUM_DIGITS) ? NUM_DONE : NUM_BAD;
            end
          end
        end
      end
      PH_VALUE_LF: begin
        if (byte_in == CH_LF) begin
          fend    = FE_HEADER;
          len_hdr = !key_mis_r && (key_pos_r == KEY_LEN);
          if (len_hdr && !(dflags_r == NUM_DIGITS || dflags_r == NUM_DONE)) begin
            phase_nxt = PH_ERROR;
          end else begin
            if (len_hdr) len_nxt = dsum_r;
            tok_nxt     = 1'b0;
            key_pos_nxt = '0;
            key_mis_nxt = 1'b0;
            dsum_nxt    = '0;
            dflags_nxt  = NUM_BLANK;
            phase_nxt   = PH_KEY;
          end
        end else begin
          phase_nxt = PH_ERROR;
        end
      end
      PH_BODY_LF: begin
        if (byte_in == CH_LF) begin
          phase_nxt = (len_r != '0) ? PH_BODY : PH_COMPLETE;
        end else begin
          phase_nxt = PH_ERROR;
        end
      end
      PH_BODY: begin
        kind         = FK_BODY;
        body_cnt_nxt = body_inc;
        if (body_inc >= len_r) phase_nxt = PH_COMPLETE;
      end
      default: begin
        // complete and error are terminal
      end
    endcase
  end

  // result fields reflect the state after this byte
  assign len_ext = {32'd0, len_nxt};

  always_comb begin
    res.data     = byte_in;
    res.kind     = kind;
    res.fend     = fend;
    res.len_hdr  = len_hdr;
    res.body_len = len_ext[31:0];
    res.state    = phase_nxt;
    res.complete = (phase_nxt == PH_COMPLETE);
    res.error    = (phase_nxt >= PH_ERROR);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_METHOD;
      tok_r      <= 1'b0;
      key_pos_r  <= '0;
      key_mis_r  <= 1'b0;
      dsum_r     <= '0;
      dflags_r   <= NUM_BLANK;
      len_r      <= '0;
      body_cnt_r <= '0;
    end else if (adv) begin
      phase_r    <= phase_nxt;
      tok_r      <= tok_nxt;
      key_pos_r  <= key_pos_nxt;
      key_mis_r  <= key_mis_nxt;
      dsum_r     <= dsum_nxt;
      dflags_r   <= dflags_nxt;
      len_r      <= len_nxt;
      body_cnt_r <= body_cnt_nxt;
    end
  end

  // checks
  `HRBP_ASSERT_NEXT(a_complete_holds, phase_r == PH_COMPLETE, phase_r == PH_COMPLETE, "left done")
  `HRBP_ASSERT_SAME(a_lenhdr_on_commit, res.len_hdr, res.fend == FE_HEADER, "stray length flag")
  `HRBP_ASSERT_NEXT(a_hold_when_idle, !adv, $stable({phase_r, len_r, dsum_r}), "state moved")
  `HRBP_ASSERT_NEXT(a_body_cnt_hold, phase_r != PH_BODY, $stable(body_cnt_r), "count moved")

endmodule

// ----- rtl/http_request_byte_parser.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// in_       in   in_tvalid/tready   in_tdata: one request byte
// out_      out  out_tvalid/tready  out_tdata: byte, length, state, flags; out_tuser: tags
//
// One word per cycle sustained unless out_ stalls; accepted words go via stage one to out_.
// Throughput is set by the parser state loop, which updates once per byte.
// Stage one holds the accepted byte; the result register holds the tagged word.
// Synchronous active-low reset returns the parser to the method state and empties both stages.
// A stalled output keeps its word; input is still taken while stage one is empty.

module http_request_byte_parser #(
  parameter int LEN_WIDTH = hrbp_pkg::LEN_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [7:0] data_out, [39:8] body_length,
                                   // [43:40] parse_state, [44] complete, [45] error
  output logic [6:0]  out_tuser    // [2:0] field_kind, [5:3] field_end, [6] length_header
);
  import hrbp_pkg::*;

  logic         s1_valid_r;
  logic [7:0]   s1_data_r;
  logic         out_valid_r;
  hrbp_result_t out_res_r;
  hrbp_result_t res;
  logic         out_free;
  logic         s1_adv;

  // handshake
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  // parser core
  hrbp_fsm #(
    .LEN_WIDTH(LEN_WIDTH)
  ) u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (s1_adv),
    .byte_in(s1_data_r),
    .res    (res)
  );

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (out_free) out_valid_r <= s1_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) s1_data_r <= in_tdata;
    if (s1_adv) out_res_r <= res;
  end

  // output packing
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.error, out_res_r.complete, out_res_r.state,
                       out_res_r.body_len, out_res_r.data};
  assign out_tuser  = {out_res_r.len_hdr, out_res_r.fend, out_res_r.kind};

endmodule
